// ===== rtl/assert_macros.svh =====
// Assertion macros for RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/gdo_pkg.sv =====
`default_nettype none

package gdo_pkg;

    // Default width of the signed day offset.
    localparam int OFFSET_BITS_DEF = 21;

    // Field widths.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int STS_W   = 2;

    // Calendar limits.
    localparam logic [YEAR_W-1:0]  YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [6:0]         YR_LO_MAX = 7'd99;

    // Year split by 100: q = (year * RECIP100) >> RECIP_SHIFT is exact below 10000.
    localparam int RECIP100_W  = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP100_W-1:0] RECIP100 = 13'd5243;
    localparam logic [YEAR_W-1:0]     HUNDRED  = 14'd100;

    // Result status codes.
    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_INVALID = 2'd1;
    localparam logic [STS_W-1:0] STS_RANGE   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the input beat
        logic split;  // quotient of year by 100
        logic init;   // year within century and century mod 4
        logic check;  // validate the date and form the day count
        logic walk;   // move one month
        logic emit;   // load the output register
    } gdo_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done;
    } gdo_stat_t;

    // Length of a month; zero for a month code outside 1..12.
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gdo_ctrl.sv =====
`default_nettype none

module gdo_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire gdo_pkg::gdo_stat_t stat,
    output gdo_pkg::gdo_cmd_t      cmd
);
    import gdo_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SPLIT = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output register can take a result when it is empty or being drained.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.walk = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gdo_dpath.sv =====
`default_nettype none

module gdo_dpath #(
    parameter int OFFSET_BITS = gdo_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire gdo_pkg::gdo_cmd_t                 cmd,
    input  wire logic [gdo_pkg::YEAR_W-1:0]        in_year,
    input  wire logic [gdo_pkg::MONTH_W-1:0]       in_month,
    input  wire logic [gdo_pkg::DAY_W-1:0]         in_day,
    input  wire logic signed [OFFSET_BITS-1:0]     day_offset,
    output gdo_pkg::gdo_stat_t                     stat,
    output logic [gdo_pkg::YEAR_W-1:0]             out_year,
    output logic [gdo_pkg::MONTH_W-1:0]            out_month,
    output logic [gdo_pkg::DAY_W-1:0]              out_day,
    output logic [gdo_pkg::STS_W-1:0]              status
);
    import gdo_pkg::*;

    // The day count needs one bit above the offset to hold day plus offset.
    localparam int DW   = OFFSET_BITS + 1;
    localparam int PW   = YEAR_W + RECIP100_W;
    localparam int QW   = PW - RECIP_SHIFT;

    logic [YEAR_W-1:0]       yr_in_reg;
    logic [MONTH_W-1:0]      mo_in_reg;
    logic [DAY_W-1:0]        dy_in_reg;
    logic [OFFSET_BITS-1:0]  off_reg;
    logic [YEAR_W-1:0]       year_reg;
    logic [MONTH_W-1:0]      month_reg;
    logic signed [DW-1:0]    d_reg;
    logic [QW-1:0]           q_reg;
    logic [6:0]              yr_lo_reg;
    logic [1:0]              cent4_reg;
    logic [STS_W-1:0]        sts_reg;
    logic [YEAR_W-1:0]       out_year_reg;
    logic [MONTH_W-1:0]      out_month_reg;
    logic [DAY_W-1:0]        out_day_reg;
    logic [STS_W-1:0]        out_sts_reg;

    logic                    leap;
    logic [MONTH_W-1:0]      prev_month;
    logic [DAY_W-1:0]        cur_len;
    logic [DAY_W-1:0]        prev_len;
    logic [DAY_W-1:0]        in_len;
    logic signed [DW-1:0]    cur_len_s;
    logic signed [DW-1:0]    prev_len_s;
    logic                    need_up;
    logic                    need_down;
    logic                    bad_date;
    logic [PW-1:0]           recip_prod;
    logic [YEAR_W-1:0]       hund_prod;
    logic [YEAR_W-1:0]       yr_rem;

    // Leap test from the year within its century and the century mod 4.
    assign leap = (yr_lo_reg[1:0] == 2'd0) && ((yr_lo_reg != 7'd0) || (cent4_reg == 2'd0));

    // Lengths of the current month and the one before it. The month before
    // January is December of the prior year, which is 31 days in any year.
    assign prev_month = (month_reg == MONTH_JAN) ? MONTH_DEC : month_reg - MONTH_JAN;
    assign cur_len    = month_len(leap, month_reg);
    assign prev_len   = month_len(leap, prev_month);
    assign in_len     = month_len(leap, mo_in_reg);
    assign cur_len_s  = $signed({{(DW-DAY_W){1'b0}}, cur_len});
    assign prev_len_s = $signed({{(DW-DAY_W){1'b0}}, prev_len});

    assign need_up   = (d_reg > cur_len_s);
    assign need_down = (d_reg <= $signed({DW{1'b0}}));

    // Input date check, valid once the century split is in place.
    assign bad_date = (yr_in_reg < YEAR_MIN) || (yr_in_reg > YEAR_MAX) ||
                      (mo_in_reg < MONTH_JAN) || (mo_in_reg > MONTH_DEC) ||
                      (dy_in_reg == '0) || (dy_in_reg > in_len);

    // Divide the year by 100 through a reciprocal, then form the remainder.
    assign recip_prod = PW'(yr_in_reg) * PW'(RECIP100);
    assign hund_prod  = YEAR_W'(q_reg) * HUNDRED;
    assign yr_rem     = yr_in_reg - hund_prod;

    assign stat.walk_done = (sts_reg != STS_OK) || (!need_up && !need_down);

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            yr_in_reg <= in_year;
            mo_in_reg <= in_month;
            dy_in_reg <= in_day;
            off_reg   <= day_offset;
            year_reg  <= in_year;
            month_reg <= in_month;
        end

        if (cmd.split)
        begin
            q_reg <= recip_prod[PW-1:RECIP_SHIFT];
        end

        if (cmd.init)
        begin
            yr_lo_reg <= yr_rem[6:0];
            cent4_reg <= q_reg[1:0];
        end

        if (cmd.check)
        begin
            sts_reg <= bad_date ? STS_INVALID : STS_OK;
            d_reg   <= $signed({{(DW-DAY_W){1'b0}}, dy_in_reg}) +
                       $signed({off_reg[OFFSET_BITS-1], off_reg});
        end

        // One month per cycle, forward or back.
        if (cmd.walk)
        begin
            if (need_up)
            begin
                if ((month_reg == MONTH_DEC) && (year_reg == YEAR_MAX))
                begin
                    sts_reg <= STS_RANGE;
                end
                else
                begin
                    d_reg <= d_reg - cur_len_s;
                    if (month_reg == MONTH_DEC)
                    begin
                        month_reg <= MONTH_JAN;
                        year_reg  <= year_reg + YEAR_MIN;
                        if (yr_lo_reg == YR_LO_MAX)
                        begin
                            yr_lo_reg <= '0;
                            cent4_reg <= cent4_reg + 2'd1;
                        end
                        else
                        begin
                            yr_lo_reg <= yr_lo_reg + 7'd1;
                        end
                    end
                    else
                    begin
                        month_reg <= month_reg + MONTH_JAN;
                    end
                end
            end
            else if (need_down)
            begin
                if ((month_reg == MONTH_JAN) && (year_reg == YEAR_MIN))
                begin
                    sts_reg <= STS_RANGE;
                end
                else
                begin
                    d_reg     <= d_reg + prev_len_s;
                    month_reg <= prev_month;
                    if (month_reg == MONTH_JAN)
                    begin
                        year_reg <= year_reg - YEAR_MIN;
                        if (yr_lo_reg == 7'd0)
                        begin
                            yr_lo_reg <= YR_LO_MAX;
                            cent4_reg <= cent4_reg - 2'd1;
                        end
                        else
                        begin
                            yr_lo_reg <= yr_lo_reg - 7'd1;
                        end
                    end
                end
            end
        end

        // Output register; on any error the input date goes back unchanged.
        if (cmd.emit)
        begin
            out_sts_reg <= sts_reg;
            if (sts_reg == STS_OK)
            begin
                out_year_reg  <= year_reg;
                out_month_reg <= month_reg;
                out_day_reg   <= d_reg[DAY_W-1:0];
            end
            else
            begin
                out_year_reg  <= yr_in_reg;
                out_month_reg <= mo_in_reg;
                out_day_reg   <= dy_in_reg;
            end
        end
    end

    assign out_year  = out_year_reg;
    assign out_month = out_month_reg;
    assign out_day   = out_day_reg;
    assign status    = out_sts_reg;

endmodule

`default_nettype wire

// ===== rtl/gregorian_date_day_offset_core.sv =====
// A beat is loaded, split by century, initialised and checked, then walked one month per cycle
// (up to about 34,450 months for the largest offset of 2**20 days) and emitted to the output register.
// A new beat is taken only once the last one has been emitted; the month loop sets the rate.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst_n, asynchronous, active low) returns the controller to idle
// and empties the output register; no calendar state survives a beat.
`default_nettype none

module gregorian_date_day_offset_core #(
    parameter int OFFSET_BITS = gdo_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [gdo_pkg::YEAR_W-1:0]    in_year,
    input  wire logic [gdo_pkg::MONTH_W-1:0]   in_month,
    input  wire logic [gdo_pkg::DAY_W-1:0]     in_day,
    input  wire logic signed [OFFSET_BITS-1:0] day_offset,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [gdo_pkg::YEAR_W-1:0]         out_year,
    output logic [gdo_pkg::MONTH_W-1:0]        out_month,
    output logic [gdo_pkg::DAY_W-1:0]          out_day,
    output logic [gdo_pkg::STS_W-1:0]          status
);
    import gdo_pkg::*;

    `include "assert_macros.svh"

    gdo_cmd_t  cmd;
    gdo_stat_t stat;

    // Sequencer.
    gdo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Calendar datapath.
    gdo_dpath #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dpath (
        .clk        (clk),
        .cmd        (cmd),
        .in_year    (in_year),
        .in_month   (in_month),
        .in_day     (in_day),
        .day_offset (day_offset),
        .stat       (stat),
        .out_year   (out_year),
        .out_month  (out_month),
        .out_day    (out_day),
        .status     (status)
    );

    // An accepted beat keeps the input side busy in the next cycle.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // A delivered result carries one of the defined status codes.
    `ASSERT_IMPLIES(a_status_code, clk, rst_n, out_valid,
        (status == STS_OK) || (status == STS_INVALID) || (status == STS_RANGE))

    // A good result is a real calendar position.
    `ASSERT_IMPLIES(a_ok_date, clk, rst_n, out_valid && (status == STS_OK),
        (out_month >= MONTH_JAN) && (out_month <= MONTH_DEC) && (out_day != '0) &&
        (out_year >= YEAR_MIN) && (out_year <= YEAR_MAX))

endmodule

`default_nettype wire

// ===== sim/gregorian_date_day_offset_core_test.sv =====
`default_nettype none

module gregorian_date_day_offset_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gdo_pkg::*;

    localparam int OFFSET_BITS  = OFFSET_BITS_DEF;
    // One beat with the largest offset walks about 34,450 months.
    localparam int STUCK_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;

    // One input beat: a starting date and the day offset.
    typedef struct packed {
        logic [YEAR_W-1:0]      year;
        logic [MONTH_W-1:0]     month;
        logic [DAY_W-1:0]       day;
        logic [OFFSET_BITS-1:0] days;
    } date_beat_t;

    // One result beat.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [STS_W-1:0]   status;
    } date_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [YEAR_W-1:0]      in_year   = '0;
    logic [MONTH_W-1:0]     in_month  = '0;
    logic [DAY_W-1:0]       in_day    = '0;
    logic [OFFSET_BITS-1:0] day_offset = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [YEAR_W-1:0]      out_year;
    logic [MONTH_W-1:0]     out_month;
    logic [DAY_W-1:0]       out_day;
    logic [STS_W-1:0]       status;

    date_beat_t   pending_beats[$];
    date_result_t expected_dates[$];
    int           send_idle_pct  = 31;
    int           recv_idle_pct  = 65;
    int           phase_index    = 0;
    logic         hold_off       = 1'b0;
    int           mismatch_count = 0;
    int           stuck_cycles   = 0;

    gregorian_date_day_offset_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_year   (in_year),
        .in_month  (in_month),
        .in_day    (in_day),
        .day_offset(day_offset),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_year  (out_year),
        .out_month (out_month),
        .out_day   (out_day),
        .status    (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Number of days in a month; zero for a month code outside 1..12.
    function automatic int days_in_month(int y, int m);
        logic leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Expected result of one beat: check the date, then walk month by month.
    function automatic date_result_t shift_date(date_beat_t b);
        date_result_t r;
        int           y;
        int           m;
        int           d;
        y = b.year;
        m = b.month;
        d = b.day;
        r.year   = b.year;
        r.month  = b.month;
        r.day    = b.day;
        r.status = STS_INVALID;
        if (y < int'(YEAR_MIN) || y > int'(YEAR_MAX) || m < int'(MONTH_JAN) ||
            m > int'(MONTH_DEC) || d < 1 || d > days_in_month(y, m))
            return r;
        r.status = STS_OK;
        d = d + int'($signed(b.days));
        // Forward walk; crossing past the last year stops it.
        while (r.status == STS_OK && d > days_in_month(y, m))
        begin
            d = d - days_in_month(y, m);
            m = m + 1;
            if (m > int'(MONTH_DEC))
            begin
                m = MONTH_JAN;
                y = y + 1;
                if (y > int'(YEAR_MAX))
                    r.status = STS_RANGE;
            end
        end
        // Backward walk; crossing below the first year stops it.
        while (r.status == STS_OK && d <= 0)
        begin
            if (m == int'(MONTH_JAN))
            begin
                m = MONTH_DEC;
                y = y - 1;
                if (y < int'(YEAR_MIN))
                    r.status = STS_RANGE;
            end
            else
                m = m - 1;
            if (r.status == STS_OK)
                d = d + days_in_month(y, m);
        end
        if (r.status == STS_OK)
        begin
            r.year  = YEAR_W'(y);
            r.month = MONTH_W'(m);
            r.day   = DAY_W'(d);
        end
        return r;
    endfunction

    function automatic void push_beat(int y, int m, int d, int off);
        date_beat_t b;
        b.year  = YEAR_W'(y);
        b.month = MONTH_W'(m);
        b.day   = DAY_W'(d);
        b.days  = OFFSET_BITS'(off);
        pending_beats.push_back(b);
    endfunction

    // Mostly valid dates with small offsets, some near the year limits, some
    // with huge offsets, and some raw noise in every field.
    task automatic queue_random(int count);
        int pick;
        int y;
        int m;
        int d;
        int off;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            y = $urandom_range(1, 9999);
            if (pick >= 20 && pick < 30)
                y = (pick % 2 != 0) ? $urandom_range(9990, 9999) : $urandom_range(1, 10);
            m = $urandom_range(1, 12);
            d = $urandom_range(1, days_in_month(y, m));
            if (pick < 15)
                push_beat($urandom_range(16383), $urandom_range(15), $urandom_range(31),
                          $urandom);
            else if (pick < 20)
                push_beat(y, m, d, $urandom);
            else if (pick < 42)
                push_beat(y, m, d, int'($urandom_range(120000)) - 60000);
            else
            begin
                off = int'($urandom_range(4000)) - 2000;
                push_beat(y, m, d, off);
            end
        end
    endtask

    task automatic wait_until_drained();
        while (pending_beats.size() != 0 || in_valid || expected_dates.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_mismatch(string what);
        $display("%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Driver: offers the next pending beat and records the prediction on accept.
    always @(posedge clk)
    begin
        date_beat_t next_beat;
        date_beat_t taken;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                taken.year  = in_year;
                taken.month = in_month;
                taken.day   = in_day;
                taken.days  = day_offset;
                expected_dates.push_back(shift_date(taken));
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_beat  = pending_beats.pop_front();
                    in_year    <= next_beat.year;
                    in_month   <= next_beat.month;
                    in_day     <= next_beat.day;
                    day_offset <= next_beat.days;
                    in_valid   <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin
        date_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_dates.size() == 0)
                report_mismatch($sformatf("result %0d-%0d-%0d status %0d with nothing expected",
                                          out_year, out_month, out_day, status));
            else
            begin
                want = expected_dates.pop_front();
                if (out_year !== want.year)
                    report_mismatch($sformatf("out_year %0d, expected %0d", out_year, want.year));
                if (out_month !== want.month)
                    report_mismatch($sformatf("out_month %0d, expected %0d",
                                              out_month, want.month));
                if (out_day !== want.day)
                    report_mismatch($sformatf("out_day %0d, expected %0d", out_day, want.day));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
            end
        end
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // Long receiver hold-off in the last phase so the block backs up.
    initial
    begin
        wait (phase_index == 2);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Leap-year rules, invalid dates, range limits and the extreme offsets.
        push_beat(2024, 2, 29, 0);
        push_beat(2023, 2, 29, 0);
        push_beat(1900, 2, 29, 0);
        push_beat(2000, 2, 29, 1);
        push_beat(1900, 2, 28, 1);
        push_beat(2100, 2, 28, 1);
        push_beat(2024, 3, 1, -1);
        push_beat(2023, 12, 31, 1);
        push_beat(2024, 1, 1, -1);
        push_beat(0, 1, 1, 0);
        push_beat(10000, 1, 1, 0);
        push_beat(16383, 15, 31, -1);
        push_beat(2020, 0, 1, 0);
        push_beat(2020, 13, 1, 0);
        push_beat(2020, 4, 31, 0);
        push_beat(2020, 1, 0, 0);
        push_beat(9999, 1, 1, 364);
        push_beat(9999, 12, 31, 1);
        push_beat(1, 1, 1, -1);
        push_beat(1, 1, 1, 1048575);
        push_beat(9999, 12, 31, -1048576);
        push_beat(1, 1, 1, -1048576);
        push_beat(9999, 12, 31, 1048575);
        push_beat(5000, 6, 15, -365);
        queue_random(27);
        wait_until_drained();

        send_idle_pct = 65;
        recv_idle_pct = 31;
        phase_index   = 1;
        queue_random(27);
        wait_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase_index   = 2;
        // Short walks first so the held output backs the block up quickly.
        push_beat(2024, 1, 15, 10);
        push_beat(2024, 5, 15, -10);
        push_beat(2023, 7, 1, 40);
        push_beat(2022, 9, 30, -40);
        queue_random(27);
        wait_until_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
